// File: rtl/interval_set_insert_merge_assert.svh
// Assertion macros used by the checker of the interval set block.
`ifndef INTERVAL_SET_INSERT_MERGE_ASSERT_SVH
`define INTERVAL_SET_INSERT_MERGE_ASSERT_SVH

// same-cycle implication
`define ISIM_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("isim check failed");

// next-cycle implication
`define ISIM_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("isim check failed");

`endif

// File: rtl/isim_pkg.sv
package isim_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int SLOT_W         = 4;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] range_begin;
        logic [FIELD_W-1:0] range_end;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic [FIELD_W-1:0] stored_begin;
        logic [FIELD_W-1:0] stored_end;
        status_t            status;
        logic               is_empty;
        logic               last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } ctrl_state_t;

    typedef struct packed {
        logic    load_in;
        logic    scan_rd;
        logic    ins_start;
        logic    ins_rd;
        logic    ins_shift;
        logic    ins_put;
        logic    emit_start;
        logic    emit_rd;
        logic    emit_ld;
        logic    status_we;
        status_t status_code;
    } cmd_t;

    typedef struct packed {
        logic bad_range;
        logic count_zero;
        logic scan_last;
        logic full_drop;
        logic ptr_zero;
        logic rd_gt;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/isim_ctrl.sv
module isim_ctrl import isim_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.bad_range) state_next = ST_EMIT_RD;
                else if (stat.count_zero) state_next = ST_INS_RD;
                else state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = stat.full_drop ? ST_EMIT_RD : ST_INS_RD;
            end
            ST_INS_RD: begin
                state_next = stat.ptr_zero ? ST_EMIT_RD : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                state_next = stat.rd_gt ? ST_INS_RD : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (stat.out_free) state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.status_code = STATUS_OK;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_CHECK: begin
                if (stat.bad_range) begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = STATUS_BAD;
                    cmd.emit_start  = 1'b1;
                end else if (stat.count_zero) begin
                    cmd.ins_start = 1'b1;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DECIDE: begin
                if (stat.full_drop) begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = STATUS_FULL;
                    cmd.emit_start  = 1'b1;
                end else begin
                    cmd.ins_start = 1'b1;
                end
            end
            ST_INS_RD: begin
                if (stat.ptr_zero) begin
                    cmd.ins_put    = 1'b1;
                    cmd.status_we  = 1'b1;
                    cmd.emit_start = 1'b1;
                end else begin
                    cmd.ins_rd = 1'b1;
                end
            end
            ST_INS_CMP: begin
                if (stat.rd_gt) begin
                    cmd.ins_shift = 1'b1;
                end else begin
                    cmd.ins_put    = 1'b1;
                    cmd.status_we  = 1'b1;
                    cmd.emit_start = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
            end
            ST_EMIT_LD: begin
                cmd.emit_ld = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/isim_dp.sv
module isim_dp import isim_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  in_t   s_data,
    output out_t  m_data,
    output logic  m_valid,
    input  logic  m_ready,
    input  cmd_t  cmd,
    output stat_t stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] b;
        logic [VALUE_BITS-1:0] e;
    } entry_t;

    entry_t mem [CAPACITY];
    entry_t rd_reg;

    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    entry_t                wr_data;

    logic [VALUE_BITS-1:0] nb_reg, ne_reg;
    logic [CW-1:0]         ptr_reg, kept_reg, count_reg;
    logic                  absorbed_reg, pend_reg, m_valid_reg;
    status_t               status_reg;
    out_t                  out_reg;

    logic                  swap, touch, absorb, keep;
    logic [VALUE_BITS-1:0] lo_e, hi_b, hi_dec;
    logic [CW-1:0]         ptr_inc;

    // touch test against the running merged interval
    assign swap   = nb_reg > rd_reg.b;
    assign lo_e   = swap ? rd_reg.e : ne_reg;
    assign hi_b   = swap ? nb_reg : rd_reg.b;
    assign hi_dec = hi_b - VALUE_BITS'(1);
    assign touch  = (hi_b == '0) || (lo_e >= hi_dec);
    assign absorb = pend_reg && touch;
    assign keep   = pend_reg && !touch;

    assign ptr_inc = CW'(ptr_reg + CW'(1));

    always_comb begin
        rd_en   = cmd.scan_rd | cmd.ins_rd | cmd.emit_rd;
        rd_addr = cmd.ins_rd ? AW'(ptr_reg - CW'(1)) : ptr_reg[AW-1:0];
        wr_en   = keep | cmd.ins_shift | cmd.ins_put;
        wr_addr = keep ? kept_reg[AW-1:0] : ptr_reg[AW-1:0];
        wr_data = cmd.ins_put ? entry_t'{b: nb_reg, e: ne_reg} : rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            nb_reg <= VALUE_BITS'(s_data.range_begin);
            ne_reg <= VALUE_BITS'(s_data.range_end);
        end else if (absorb) begin
            if (rd_reg.b < nb_reg) nb_reg <= rd_reg.b;
            if (rd_reg.e > ne_reg) ne_reg <= rd_reg.e;
        end

        if (cmd.load_in) kept_reg <= '0;
        else if (keep) kept_reg <= CW'(kept_reg + CW'(1));

        if (cmd.load_in) absorbed_reg <= 1'b0;
        else if (absorb) absorbed_reg <= 1'b1;

        if (cmd.load_in || cmd.emit_start) ptr_reg <= '0;
        else if (cmd.scan_rd || cmd.emit_ld) ptr_reg <= ptr_inc;
        else if (cmd.ins_start) ptr_reg <= kept_reg;
        else if (cmd.ins_shift) ptr_reg <= CW'(ptr_reg - CW'(1));

        if (cmd.status_we) status_reg <= cmd.status_code;

        if (cmd.emit_ld) begin
            out_reg.slot_index   <= SLOT_W'(ptr_reg);
            out_reg.stored_begin <= stat.count_zero ? '0 : FIELD_W'(rd_reg.b);
            out_reg.stored_end   <= stat.count_zero ? '0 : FIELD_W'(rd_reg.e);
            out_reg.status       <= status_reg;
            out_reg.is_empty     <= stat.count_zero;
            out_reg.last         <= stat.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ins_put) count_reg <= CW'(kept_reg + CW'(1));
            pend_reg <= cmd.scan_rd;
            if (cmd.emit_ld) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.bad_range  = nb_reg >= ne_reg;
        stat.count_zero = count_reg == '0;
        stat.scan_last  = ptr_inc == count_reg;
        stat.full_drop  = !absorbed_reg && (count_reg == CW'(CAPACITY));
        stat.ptr_zero   = ptr_reg == '0;
        stat.rd_gt      = rd_reg.b > nb_reg;
        stat.emit_last  = (count_reg == '0) || (ptr_inc == count_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/interval_set_insert_merge.sv
// Flow: an input is checked, the stored intervals are scanned and merged with it,
// the insert shifts later ones up, and then the table is sent out as result
// words, which output stalls can hold back.
// One input is handled at a time; the dual-port table (one read, one write a
// cycle) sets the pace. Reset (aresetn, synchronous, active low) empties the
// table at once; the table contents need no clearing pass.
module interval_set_insert_merge import isim_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t  cmd;
    stat_t stat;

    isim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    isim_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// File: rtl/isim_checker.sv
`include "interval_set_insert_merge_assert.svh"

module isim_checker import isim_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    `ISIM_AST_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `ISIM_AST_IMP(a_empty_last, aclk, aresetn, m_valid && m_data.is_empty, m_data.last && m_data.slot_index == '0)
    `ISIM_AST_IMP(a_ok_nonempty, aclk, aresetn, m_valid && m_data.status == STATUS_OK, !m_data.is_empty)
    `ISIM_AST_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind interval_set_insert_merge isim_checker u_chk (.*);
